@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and helpers for the priority process scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCESS = 31;
  localparam int PID_W       = 5;
  localparam int NSLOT       = 32;
  localparam int PRI_W       = 32;
  localparam int QUANT_W     = 16;
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;

  typedef enum logic [2:0] {
    REQ_CLOCK  = 3'd0,
    REQ_SLEEP  = 3'd1,
    REQ_DEPART = 3'd2,
    REQ_WAKE   = 3'd3,
    REQ_KILL   = 3'd4,
    REQ_ARRIVE = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    CODE_OK          = 3'd0,
    CODE_BAD_PID     = 3'd1,
    CODE_PID_IN_USE  = 3'd2,
    CODE_NOT_FOUND   = 3'd3,
    CODE_NOT_BLOCKED = 3'd4,
    CODE_NO_RUNNING  = 3'd5
  } code_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_READY   = 2'd3
  } pstat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RESCHED,
    S_PICK,
    S_SCAN,
    S_TAKE,
    S_FIND,
    S_RESP
  } state_t;

  typedef struct packed {
    logic  load;
    logic  clk_add;
    logic  sleep_blk;
    logic  stop_run;
    logic  push_pid;
    logic  push_wr;
    logic  push_run;
    logic  scan_init;
    logic  scan_step;
    logic  take;
    logic  clear_run;
    logic  kill_unused;
    logic  find_step;
    logic  set_code;
    code_t code;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       pid_ok;
    pstat_t     pid_st;
    logic       run_valid;
    logic       count_zero;
    logic       scan_done;
    logic       find_hit;
    logic       find_end;
  } sts_t;

  function automatic logic signed [PRI_W-1:0] sat_add(
    input logic signed [PRI_W-1:0] a,
    input logic signed [PRI_W-1:0] b
  );
    logic signed [PRI_W:0] s;
    s = {a[PRI_W-1], a} + {b[PRI_W-1], b};
    if (s[PRI_W] != s[PRI_W-1]) begin
      sat_add = s[PRI_W] ? {1'b1, {(PRI_W-1){1'b0}}} : {1'b0, {(PRI_W-1){1'b1}}};
    end else begin
      sat_add = s[PRI_W-1:0];
    end
  endfunction

endpackage

@@ rtl/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Event sequencer: decodes a request and steps the datapath through
// reschedule, minimum scan, list search and result hand-off.
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic pid_req;
  assign pid_req = (sts.req == REQ_WAKE) || (sts.req == REQ_KILL) || (sts.req == REQ_ARRIVE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_RESP;
        if (!(pid_req && !sts.pid_ok)) begin
          case (sts.req)
            REQ_CLOCK:  if (sts.run_valid) state_next = S_RESCHED;
            REQ_SLEEP:  if (sts.run_valid) state_next = S_PICK;
            REQ_DEPART: if (sts.run_valid) state_next = S_PICK;
            REQ_WAKE:   if (sts.pid_st == ST_BLOCKED) state_next = S_RESCHED;
            REQ_KILL: begin
              if (sts.pid_st == ST_RUNNING) state_next = S_PICK;
              else if (sts.pid_st == ST_READY) state_next = S_FIND;
            end
            REQ_ARRIVE: if (sts.pid_st == ST_UNUSED) state_next = S_RESCHED;
            default: state_next = S_RESP;
          endcase
        end
      end
      S_RESCHED: state_next = S_PICK;
      S_PICK:    state_next = sts.count_zero ? S_RESP : S_SCAN;
      S_SCAN:    if (sts.scan_done) state_next = S_TAKE;
      S_TAKE:    state_next = S_RESP;
      S_FIND:    if (sts.find_hit || sts.find_end) state_next = S_RESP;
      S_RESP:    if (out_ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.code = CODE_OK;
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: begin
        cmd.set_code = 1'b1;
        if (pid_req && !sts.pid_ok) begin
          cmd.code = CODE_BAD_PID;
        end else begin
          case (sts.req)
            REQ_CLOCK: cmd.clk_add = sts.run_valid;
            REQ_SLEEP: begin
              cmd.sleep_blk = sts.run_valid;
              if (!sts.run_valid) cmd.code = CODE_NO_RUNNING;
            end
            REQ_DEPART: begin
              cmd.stop_run = sts.run_valid;
              if (!sts.run_valid) cmd.code = CODE_NO_RUNNING;
            end
            REQ_WAKE: begin
              cmd.push_pid = (sts.pid_st == ST_BLOCKED);
              if (sts.pid_st != ST_BLOCKED) cmd.code = CODE_NOT_BLOCKED;
            end
            REQ_KILL: begin
              cmd.stop_run    = (sts.pid_st == ST_RUNNING);
              cmd.kill_unused = (sts.pid_st == ST_READY) || (sts.pid_st == ST_BLOCKED);
              cmd.scan_init   = (sts.pid_st == ST_READY);
              if (sts.pid_st == ST_UNUSED) cmd.code = CODE_NOT_FOUND;
            end
            REQ_ARRIVE: begin
              cmd.push_pid = (sts.pid_st == ST_UNUSED);
              cmd.push_wr  = (sts.pid_st == ST_UNUSED);
              if (sts.pid_st != ST_UNUSED) cmd.code = CODE_PID_IN_USE;
            end
            default: cmd.code = CODE_OK;
          endcase
        end
      end
      S_RESCHED: cmd.push_run = 1'b1;
      S_PICK: begin
        cmd.clear_run = sts.count_zero;
        cmd.scan_init = !sts.count_zero;
      end
      S_SCAN:  cmd.scan_step = 1'b1;
      S_TAKE:  cmd.take = 1'b1;
      S_FIND:  cmd.find_step = 1'b1;
      default: cmd.load = 1'b0;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);

endmodule

@@ rtl/pps_datapath.sv @@
// ----------------------------------------------------------------------------
// pps_datapath
// Process table, ordered ready list, priority memory, running process and
// the minimum-priority scan.
// ----------------------------------------------------------------------------
module pps_datapath
  import pps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [QUANT_W-1:0]       cfg_wr_data,
  input  logic [2:0]               req_type,
  input  logic [5:0]               pid,
  input  logic signed [PRI_W-1:0]  priority_req,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output code_t                    code,
  output logic                     run_valid,
  output logic [PID_W-1:0]         run_pid,
  output logic signed [PRI_W-1:0]  run_pri
);

  logic [QUANT_W-1:0]       quantum;
  logic [2:0]               req_r;
  logic [5:0]               pid_r;
  logic signed [PRI_W-1:0]  preq_r;

  pstat_t                   pstat [NSLOT];
  logic signed [PRI_W-1:0]  pri_mem [NSLOT];
  logic [PID_W-1:0]         order [MAX_PROCESS];
  logic [PID_W-1:0]         count;

  logic [PID_W-1:0]         scan_idx;
  logic [PID_W-1:0]         cmp_idx;
  logic [PID_W-1:0]         cmp_pid;
  logic                     cmp_vld;
  logic signed [PRI_W-1:0]  rd_data;
  logic [PID_W-1:0]         best_idx;
  logic [PID_W-1:0]         best_pid;
  logic signed [PRI_W-1:0]  best_pri;

  logic                     scan_live;
  logic [PID_W-1:0]         order_rd;
  logic                     do_push;
  logic [PID_W-1:0]         push_val;
  logic                     do_remove;
  logic [PID_W-1:0]         rm_idx;
  logic                     st_we;
  logic [PID_W-1:0]         st_addr;
  pstat_t                   st_val;
  logic                     mem_we;
  logic [PID_W-1:0]         mem_addr;
  logic signed [PRI_W-1:0]  mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_wr_en) begin
      quantum <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_type;
      pid_r  <= pid;
      preq_r <= priority_req;
    end
    if (cmd.set_code) code <= cmd.code;
  end

  // single indexed read of the ready list, shared by scan and search
  assign scan_live = (scan_idx < count);
  assign order_rd  = scan_live ? order[scan_idx] : '0;

  assign do_push   = cmd.push_pid || (cmd.push_run && run_valid);
  assign push_val  = cmd.push_pid ? pid_r[PID_W-1:0] : run_pid;
  assign do_remove = cmd.take || (cmd.find_step && sts.find_hit);
  assign rm_idx    = cmd.take ? best_idx : scan_idx;

  always_comb begin
    st_we   = 1'b1;
    st_addr = run_pid;
    st_val  = ST_UNUSED;
    if (cmd.sleep_blk) begin
      st_val = ST_BLOCKED;
    end else if (cmd.stop_run) begin
      st_val = ST_UNUSED;
    end else if (cmd.push_pid) begin
      st_addr = pid_r[PID_W-1:0];
      st_val  = ST_READY;
    end else if (cmd.push_run) begin
      st_we  = run_valid;
      st_val = ST_READY;
    end else if (cmd.kill_unused) begin
      st_addr = pid_r[PID_W-1:0];
      st_val  = ST_UNUSED;
    end else if (cmd.take) begin
      st_addr = best_pid;
      st_val  = ST_RUNNING;
    end else begin
      st_we = 1'b0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = run_pid;
    mem_wdata = run_pri;
    if (cmd.sleep_blk) begin
      mem_we    = 1'b1;
      mem_wdata = sat_add(run_pri, preq_r);
    end else if (cmd.push_pid && cmd.push_wr) begin
      mem_we    = 1'b1;
      mem_addr  = pid_r[PID_W-1:0];
      mem_wdata = preq_r;
    end else if (cmd.push_run) begin
      mem_we = run_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) pstat[i] <= ST_UNUSED;
    end else if (st_we) begin
      pstat[st_addr] <= st_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pri_mem[mem_addr] <= mem_wdata;
    rd_data <= pri_mem[order_rd];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      for (int i = MAX_PROCESS - 1; i > 0; i--) order[i] <= order[i-1];
      order[0] <= push_val;
    end else if (do_remove) begin
      for (int i = 0; i < MAX_PROCESS - 1; i++) begin
        if (PID_W'(i) >= rm_idx) order[i] <= order[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_push) begin
      count <= count + 1'b1;
    end else if (do_remove) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld  <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.scan_init) begin
      cmp_vld  <= 1'b0;
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      cmp_vld <= scan_live;
      if (scan_live) scan_idx <= scan_idx + 1'b1;
    end else if (cmd.find_step && !sts.find_hit && scan_live) begin
      scan_idx <= scan_idx + 1'b1;
    end else begin
      cmp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx <= scan_idx;
      cmp_pid <= order_rd;
    end
    // strict less-than keeps the entry nearest the front on a tie
    if (cmp_vld && ((cmp_idx == '0) || (rd_data < best_pri))) begin
      best_pri <= rd_data;
      best_idx <= cmp_idx;
      best_pid <= cmp_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_pid   <= '0;
      run_pri   <= '0;
    end else if (cmd.clk_add) begin
      run_pri <= sat_add(run_pri, PRI_W'(quantum));
    end else if (cmd.sleep_blk || cmd.stop_run || (cmd.push_run && run_valid)) begin
      run_valid <= 1'b0;
    end else if (cmd.take) begin
      run_valid <= 1'b1;
      run_pid   <= best_pid;
      run_pri   <= best_pri;
    end else if (cmd.clear_run) begin
      run_valid <= 1'b0;
      run_pid   <= '0;
      run_pri   <= '0;
    end
  end

  always_comb begin
    sts.req        = req_r;
    sts.pid_ok     = (pid_r != '0) && (pid_r <= 6'(MAX_PROCESS));
    sts.pid_st     = pstat[pid_r[PID_W-1:0]];
    sts.run_valid  = run_valid;
    sts.count_zero = (count == '0);
    sts.scan_done  = cmp_vld && (cmp_idx == count - 1'b1);
    sts.find_hit   = scan_live && (order_rd == pid_r[PID_W-1:0]);
    sts.find_end   = !scan_live;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= PID_W'(MAX_PROCESS))
    else $error("ready list overfull");

  a_take_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> run_valid && (pstat[run_pid] == ST_RUNNING))
    else $error("picked process not running");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.push_pid |=> count == $past(count) + 1'b1)
    else $error("push did not grow the ready list");

endmodule

@@ rtl/priority_process_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_process_scheduler
// Process scheduler with per-pid state, an ordered ready list and a
// least-priority pick on every reschedule.
// ----------------------------------------------------------------------------
// Sequence: a taken event is decoded, and its response word follows when no pick is
//   needed; else reschedule, pick, a scan of the ready entries, one priority read
//   per entry, and take (sleep and depart skip reschedule); kill of a ready pid
//   searches the list instead.
// Throughput: one event at a time, the next taken the cycle after the word leaves.
// Reset: synchronous; all pids unused, empty ready list, nothing running, quantum 10.
module priority_process_scheduler
  import pps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [QUANT_W-1:0]      cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              req_type,
  input  logic [5:0]              pid,
  input  logic signed [PRI_W-1:0] priority_req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              status_code,
  output logic                    running_valid,
  output logic [PID_W-1:0]        running_pid,
  output logic signed [PRI_W-1:0] running_pri
);

  cmd_t                    cmd;
  sts_t                    sts;
  code_t                   code;
  logic                    run_valid;
  logic [PID_W-1:0]        run_pid;
  logic signed [PRI_W-1:0] run_pri;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pps_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req_type     (req_type),
    .pid          (pid),
    .priority_req (priority_req),
    .cmd          (cmd),
    .sts          (sts),
    .code         (code),
    .run_valid    (run_valid),
    .run_pid      (run_pid),
    .run_pri      (run_pri)
  );

  assign status_code   = code;
  assign running_valid = run_valid;
  assign running_pid   = run_valid ? run_pid : '0;
  assign running_pri   = run_valid ? run_pri : '0;

endmodule

@@ tb/tb_priority_process_scheduler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_process_scheduler
// Self-checking bench for the process scheduler: a queue-fed driver sends
// scheduling events, a monitor compares every response word with the
// bench's own model of process state, ready list and running process.
// ----------------------------------------------------------------------------
module tb_priority_process_scheduler;
  import pps_pkg::*;

  localparam int PRI_MAX = 32'sh7fffffff;
  localparam int PRI_MIN = -32'sh7fffffff - 1;

  typedef struct {
    logic [2:0]  req;
    logic [5:0]  pid;
    logic [31:0] pri;
  } event_t;

  typedef struct {
    code_t       code;
    logic        rv;
    logic [4:0]  rpid;
    logic [31:0] rpri;
  } resp_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [QUANT_W-1:0] cfg_wr_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] req_type;
  logic [5:0] pid;
  logic signed [PRI_W-1:0] priority_req;
  logic [2:0] status_code;
  logic running_valid;
  logic [PID_W-1:0] running_pid;
  logic signed [PRI_W-1:0] running_pri;

  priority_process_scheduler DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .pid(pid), .priority_req(priority_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .status_code(status_code), .running_valid(running_valid),
    .running_pid(running_pid), .running_pri(running_pri)
  );

  // scheduler model
  logic [15:0]       m_quantum;
  pstat_t            m_stat [NSLOT];
  logic signed [31:0] m_pri [NSLOT];
  logic [4:0]        m_order [$];
  logic              m_rv;
  logic [4:0]        m_rpid;
  logic signed [31:0] m_rpri;

  event_t pending_events [$];
  resp_t  expected_resps [$];
  int     errors;
  int     in_gap, out_gap;
  logic   hold_send;

  function automatic logic signed [31:0] sat32(longint s);
    if (s > longint'(PRI_MAX)) return PRI_MAX;
    if (s < longint'(PRI_MIN)) return PRI_MIN;
    return s[31:0];
  endfunction

  function automatic void sched_push(logic [4:0] p, logic signed [31:0] pr);
    m_order.push_front(p);
    m_stat[p] = ST_READY;
    m_pri[p] = pr;
  endfunction

  function automatic void sched_pick();
    int best;
    best = 0;
    if (m_order.size() == 0) begin
      m_rv = 0; m_rpid = 0; m_rpri = 0;
      return;
    end
    for (int i = 1; i < m_order.size(); i++)
      if (m_pri[m_order[i]] < m_pri[m_order[best]]) best = i;
    m_rpid = m_order[best];
    m_order.delete(best);
    m_rv = 1;
    m_rpri = m_pri[m_rpid];
    m_stat[m_rpid] = ST_RUNNING;
  endfunction

  function automatic void sched_resched();
    if (m_rv) sched_push(m_rpid, m_rpri);
    sched_pick();
  endfunction

  function automatic void sched_stop();
    m_stat[m_rpid] = ST_UNUSED;
    m_rv = 0;
    sched_pick();
  endfunction

  function automatic resp_t schedule_event(event_t e);
    resp_t r;
    logic [4:0] p;
    logic ok;
    code_t c;
    c = CODE_OK;
    p = e.pid[4:0];
    ok = e.pid >= 1 && e.pid <= MAX_PROCESS;
    if ((e.req == REQ_WAKE || e.req == REQ_KILL || e.req == REQ_ARRIVE) && !ok)
      c = CODE_BAD_PID;
    else case (e.req)
      REQ_CLOCK: if (m_rv) begin
        m_rpri = sat32(longint'(m_rpri) + longint'(m_quantum));
        sched_resched();
      end
      REQ_SLEEP: if (m_rv) begin
        m_pri[m_rpid] = sat32(longint'(m_rpri) + longint'($signed(e.pri)));
        m_stat[m_rpid] = ST_BLOCKED;
        m_rv = 0;
        sched_pick();
      end else c = CODE_NO_RUNNING;
      REQ_DEPART: if (m_rv) sched_stop(); else c = CODE_NO_RUNNING;
      REQ_WAKE: if (m_stat[p] == ST_BLOCKED) begin
        sched_push(p, m_pri[p]);
        sched_resched();
      end else c = CODE_NOT_BLOCKED;
      REQ_KILL: case (m_stat[p])
        ST_RUNNING: sched_stop();
        ST_READY: begin
          for (int i = 0; i < m_order.size(); i++)
            if (m_order[i] == p) begin
              m_order.delete(i);
              break;
            end
          m_stat[p] = ST_UNUSED;
        end
        ST_BLOCKED: m_stat[p] = ST_UNUSED;
        default: c = CODE_NOT_FOUND;
      endcase
      REQ_ARRIVE: if (m_stat[p] == ST_UNUSED) begin
        sched_push(p, e.pri);
        sched_resched();
      end else c = CODE_PID_IN_USE;
      default: ;
    endcase
    r.code = c;
    r.rv = m_rv;
    r.rpid = m_rv ? m_rpid : 5'd0;
    r.rpri = m_rv ? m_rpri : 32'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      in_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // hold until taken
    end else if (in_gap > 0) begin
      in_valid <= 0;
      in_gap <= in_gap - 1;
    end else if (pending_events.size() > 0 && !hold_send) begin
      event_t e;
      e = pending_events.pop_front();
      in_valid <= 1;
      req_type <= e.req;
      pid <= e.pid;
      priority_req <= e.pri;
      expected_resps.push_back(schedule_event(e));
      in_gap <= pick_gap();
    end else begin
      in_valid <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $display("unexpected response word at %0t", $realtime);
          errors++;
        end else begin
          resp_t x;
          x = expected_resps.pop_front();
          if (status_code !== x.code) report_mismatch("status_code", status_code, x.code);
          if (running_valid !== x.rv) report_mismatch("running_valid", running_valid, x.rv);
          if (running_pid !== x.rpid) report_mismatch("running_pid", running_pid, x.rpid);
          if (running_pri !== x.rpri) report_mismatch("running_pri", running_pri, x.rpri);
        end
      end
      if (out_gap > 0) begin
        out_ready <= 0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  function automatic logic [31:0] rand_pri();
    case ($urandom_range(0, 5))
      0: return PRI_MAX - $urandom_range(0, 40);
      1: return PRI_MIN + $urandom_range(0, 40);
      2: return $urandom;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  function automatic void add_event(logic [2:0] rq, logic [5:0] p, logic [31:0] pr);
    event_t e;
    e.req = rq; e.pid = p; e.pri = pr;
    pending_events.push_back(e);
  endfunction

  function automatic void add_random(int n);
    int r;
    logic [2:0] rq;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22) rq = REQ_CLOCK;
      else if (r < 34) rq = REQ_SLEEP;
      else if (r < 42) rq = REQ_DEPART;
      else if (r < 60) rq = REQ_WAKE;
      else if (r < 72) rq = REQ_KILL;
      else if (r < 97) rq = REQ_ARRIVE;
      else rq = 3'($urandom_range(6, 7));
      // mostly valid pids, a few out of range
      add_event(rq, ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63))
                    : 6'($urandom_range(1, 12) + (($urandom_range(0, 3) == 0) ? 19 : 0)),
                rand_pri());
    end
  endfunction

  task automatic drain();
    while (pending_events.size() > 0 || expected_resps.size() > 0 || in_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_quantum(logic [15:0] q);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= q;
    m_quantum = q;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  initial begin
    errors = 0;
    hold_send = 0;
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    req_type = 0;
    pid = 0;
    priority_req = 0;
    m_quantum = QUANTUM_RESET;
    m_rv = 0; m_rpid = 0; m_rpri = 0;
    for (int i = 0; i < NSLOT; i++) begin
      m_stat[i] = ST_UNUSED;
      m_pri[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: error codes, extremes, every event
    add_event(REQ_CLOCK, 0, 0);
    add_event(REQ_SLEEP, 0, 0);
    add_event(REQ_DEPART, 0, 0);
    add_event(REQ_WAKE, 0, 0);
    add_event(REQ_KILL, 63, 0);
    add_event(REQ_ARRIVE, 32, 0);
    add_event(REQ_KILL, 5, 0);
    add_event(REQ_ARRIVE, 31, PRI_MAX - 3);
    add_event(REQ_ARRIVE, 1, PRI_MIN);
    add_event(REQ_ARRIVE, 2, PRI_MIN);
    add_event(REQ_ARRIVE, 1, 0);
    add_event(REQ_WAKE, 2, 0);
    add_event(REQ_SLEEP, 0, PRI_MIN);
    add_event(REQ_WAKE, 2, 0);
    add_event(REQ_CLOCK, 0, 0);
    add_event(REQ_KILL, 1, 0);
    add_event(REQ_CLOCK, 0, 0);
    add_event(REQ_SLEEP, 0, PRI_MAX);
    add_event(REQ_KILL, 31, 0);
    add_event(6, 7, 32'hffffffff);
    add_event(7, 0, 0);
    add_event(REQ_DEPART, 0, 0);
    add_event(REQ_KILL, 2, 0);
    drain();

    write_quantum(16'hffff);
    add_random(300);
    drain();
    write_quantum(0);
    add_random(300);
    // let everything settle with the sender held off
    wait (pending_events.size() == 0);
    hold_send = 1;
    while (expected_resps.size() > 0 || in_valid) @(posedge clk);
    hold_send = 0;
    add_random(300);
    drain();
    write_quantum(16'd1);
    add_random(450);
    drain();
    write_quantum(16'h8000);
    add_random(480);
    drain();

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
